// ===== design/pli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the bounded positional list.
// ----------------------------------------------------------------------------
package pli_pkg;

  // Default number of entries the list can hold.
  localparam int unsigned DEF_CAPACITY = 16;

  // Value returned for every insert, every unused code and every failed command.
  localparam logic signed [31:0] FAIL_VALUE = -32'sd9999;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_REM_HEAD = 3'd3,
    CMD_REM_TAIL = 3'd4,
    CMD_REM_POS  = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // What a cell does with its entry in each cycle.
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_FROM_LEFT  = 2'd2,
    OP_FROM_RIGHT = 2'd3
  } cell_op_t;

  // Control handed from the list controller to each cell.
  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

// ===== design/positional_list_insert_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_remove
// Bounded ordered list of signed 32-bit values with insert and remove at the
// head, the tail or a given position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
//   Channel   Ports                                   Transfer when
//   command   start, busy, cmd, value, position       start && !busy
//   result    done, removed_value, status, count_after  done
//
// Every command is taken as soon as it is given; all cells shift in parallel, so a
// new command can be given in every cycle and busy stays low.
// The result appears in the cycle after the command, for exactly one cycle.
// Synchronous reset empties the list; entry contents are not cleared.
// The receiver cannot stall the result.
module positional_list_insert_remove #(
  parameter int unsigned CAPACITY = pli_pkg::DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [7:0]         position,
  output logic               done,
  output logic signed [31:0] removed_value,
  output logic [1:0]         status,
  output logic [4:0]         count_after
);
  import pli_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 8) ? CW : 8;

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [XW-1:0]      cnt_x;
  logic [XW-1:0]      at;
  logic               is_ins;
  logic               is_rem;
  logic               ok;
  status_t            st;
  logic signed [31:0] got;
  logic               accept;

  logic signed [31:0] cell_data [CAPACITY];
  cell_ctrl_t         cell_ctrl [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cnt_x  = XW'(count);

  // Decode the command: target position, legality and status.
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    at     = '0;
    case (cmd)
      CMD_INS_HEAD: begin
        is_ins = 1'b1;
      end
      CMD_INS_TAIL: begin
        is_ins = 1'b1;
        at     = cnt_x;
      end
      CMD_INS_POS: begin
        is_ins = 1'b1;
        at     = XW'(position);
      end
      CMD_REM_HEAD: begin
        is_rem = 1'b1;
      end
      CMD_REM_TAIL: begin
        is_rem = 1'b1;
        at     = (count == '0) ? '0 : cnt_x - XW'(1);
      end
      CMD_REM_POS: begin
        is_rem = 1'b1;
        at     = XW'(position);
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase

    st = ST_OK;
    if (is_ins) begin
      if (at > cnt_x) begin
        st = ST_BADPOS;
      end else if (cnt_x >= XW'(CAPACITY)) begin
        st = ST_FULL;
      end
    end else if (is_rem) begin
      if (count == '0) begin
        st = ST_EMPTY;
      end else if (at >= cnt_x) begin
        st = ST_BADPOS;
      end
    end
    ok = (is_ins || is_rem) && (st == ST_OK);

    count_next = count;
    if (ok && is_ins) begin
      count_next = count + CW'(1);
    end else if (ok && is_rem) begin
      count_next = count - CW'(1);
    end
  end

  // Read the entry at the target position for removals.
  always_comb begin
    got = FAIL_VALUE;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ok && is_rem && (at == XW'(i))) begin
        got = cell_data[i];
      end
    end
  end

  // Cell ops: insert loads target, remove shifts it, later cells shift, rest hold.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].op = OP_HOLD;
      if (accept && ok && is_ins) begin
        if (XW'(i) == at) begin
          cell_ctrl[i].op = OP_LOAD;
        end else if (XW'(i) > at) begin
          cell_ctrl[i].op = OP_FROM_LEFT;
        end
      end else if (accept && ok && is_rem) begin
        if (XW'(i) >= at) begin
          cell_ctrl[i].op = OP_FROM_RIGHT;
        end
      end
    end
  end

  // Row of cells, each wired to its neighbors.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] left_d;
      logic signed [31:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = FAIL_VALUE;
      end else begin : g_mid_l
        assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = cell_data[g];
      end else begin : g_mid_r
        assign right_d = cell_data[g+1];
      end
      pli_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl[g]),
        .load_data (value),
        .left_data (left_d),
        .right_data(right_d),
        .data      (cell_data[g])
      );
    end
  endgenerate

  // Count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= got;
      status        <= st;
      count_after   <= 5'(count_next);
    end
  end

endmodule

// ===== design/pli_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_cell
// One entry of the list; takes a new value, its left or right neighbor's
// entry, or keeps its own.
// ----------------------------------------------------------------------------
module pli_cell (
  input  logic                clk,
  input  pli_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]  load_data,
  input  logic signed [31:0]  left_data,
  input  logic signed [31:0]  right_data,
  output logic signed [31:0]  data
);
  import pli_pkg::*;

  logic signed [31:0] data_next;

  // Pick the source of the entry for the next cycle.
  always_comb begin
    case (ctrl.op)
      OP_LOAD:       data_next = load_data;
      OP_FROM_LEFT:  data_next = left_data;
      OP_FROM_RIGHT: data_next = right_data;
      default:       data_next = data;
    endcase
  end

  // Entry register; contents are meaningless until written.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== sim/list_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_result_checker
// Watches the command and result channels of the positional list, keeps a
// shadow copy of the list, and compares every result with its prediction.
// ----------------------------------------------------------------------------
module list_result_checker #(
  parameter int unsigned CAPACITY = pli_pkg::DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [7:0]         position,
  input  logic               done,
  input  logic signed [31:0] removed_value,
  input  logic [1:0]         status,
  input  logic [4:0]         count_after,
  output int unsigned        pending,
  output int unsigned        fail_count,
  output int unsigned        checked,
  output logic [3:0]         status_seen
);
  import pli_pkg::*;

  // One predicted result of a command.
  typedef struct {
    logic signed [31:0] removed;
    status_t            st;
    logic [4:0]         count;
  } list_result_t;

  logic signed [31:0] shadow_entries [CAPACITY];
  int unsigned        shadow_count;
  list_result_t       results_due [$];

  initial begin
    fail_count  = 0;
    checked     = 0;
    status_seen = '0;
  end

  // Apply one command to the shadow list and return what the block must report.
  function automatic list_result_t apply_list_command(logic [2:0] code,
                                                      logic signed [31:0] data,
                                                      logic [7:0] pos);
    list_result_t r;
    int unsigned  at;
    r.removed = FAIL_VALUE;
    r.st      = ST_OK;
    case (code)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (code == CMD_INS_HEAD) at = 0;
        else if (code == CMD_INS_TAIL) at = shadow_count;
        else at = pos;
        // A bad position is reported ahead of a full list.
        if (at > shadow_count) begin
          r.st = ST_BADPOS;
        end else if (shadow_count >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          for (int i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[at] = data;
          shadow_count++;
        end
      end
      CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_POS: begin
        if (code == CMD_REM_HEAD) at = 0;
        else if (code == CMD_REM_TAIL) at = (shadow_count == 0) ? 0 : shadow_count - 1;
        else at = pos;
        // An empty list is reported ahead of a bad position.
        if (shadow_count == 0) begin
          r.st = ST_EMPTY;
        end else if (at >= shadow_count) begin
          r.st = ST_BADPOS;
        end else begin
          r.removed = shadow_entries[at];
          for (int i = at; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      // Unused codes leave the list alone and report success.
      default: begin
      end
    endcase
    r.count = 5'(shadow_count);
    return r;
  endfunction

  // Retire the oldest expectation on each result, then predict each new transfer.
  always @(posedge clk) begin
    list_result_t due;
    if (rst) begin
      shadow_count = 0;
      results_due.delete();
      pending <= 0;
    end else begin
      if (done) begin
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: result with nothing expected: value %0d status %0d count %0d",
                     removed_value, status, count_after);
        end else begin
          due = results_due.pop_front();
          checked++;
          status_seen[due.st] = 1'b1;
          if (removed_value !== due.removed || status !== due.st ||
              count_after !== due.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected value %0d status %0d count %0d, got %0d %0d %0d",
                       due.removed, due.st, due.count, removed_value, status, count_after);
          end
        end
      end
      if (start && !busy) results_due.push_back(apply_list_command(cmd, value, position));
      pending <= results_due.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random list commands into the positional list, with
// random idle bursts, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module testbench;
  import pli_pkg::*;

  localparam int unsigned CAPACITY     = DEF_CAPACITY;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned SEGMENT      = 50;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Command codes the block does not define.
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         cmd;
  logic signed [31:0] value;
  logic [7:0]         position;
  logic               done;
  logic signed [31:0] removed_value;
  logic [1:0]         status;
  logic [4:0]         count_after;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned checked;
  logic [3:0]  status_seen;
  int unsigned sent = 0;
  int unsigned cycle_count = 0;

  positional_list_insert_remove #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .value(value),
    .position(position), .done(done), .removed_value(removed_value),
    .status(status), .count_after(count_after)
  );

  list_result_checker #(.CAPACITY(CAPACITY)) result_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .value(value),
    .position(position), .done(done), .removed_value(removed_value),
    .status(status), .count_after(count_after), .pending(pending),
    .fail_count(fail_count), .checked(checked), .status_seen(status_seen)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one command and hold it until the block takes the transfer.
  task automatic send_command(logic [2:0] code, logic signed [31:0] data, logic [7:0] pos);
    start    <= 1'b1;
    cmd      <= code;
    value    <= data;
    position <= pos;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off new commands until every predicted result has come back or the wait limit runs out.
  task automatic drain_results(int unsigned limit);
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Choose a command, leaning toward inserts or removals by the given share.
  function automatic logic [2:0] pick_code(int unsigned insert_pct);
    if ($urandom_range(0, 99) < 3) return $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
    if ($urandom_range(0, 99) < insert_pct)
      return 3'($urandom_range(CMD_INS_HEAD, CMD_INS_POS));
    return 3'($urandom_range(CMD_REM_HEAD, CMD_REM_POS));
  endfunction

  // Mostly positions near the valid range, now and then anything at all.
  function automatic logic [7:0] pick_position();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, CAPACITY + 1));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned insert_pct;
    int unsigned idle_pct;
    rst      <= 1'b1;
    start    <= 1'b0;
    cmd      <= CMD_INS_HEAD;
    value    <= '0;
    position <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Removals from an empty list, including one with a wild position.
    send_command(CMD_REM_HEAD, $urandom(), 8'($urandom()));
    send_command(CMD_REM_TAIL, $urandom(), 8'($urandom()));
    send_command(CMD_REM_POS, $urandom(), 8'd200);
    // Insert past the end of an empty list.
    send_command(CMD_INS_POS, $urandom(), 8'd1);
    // Build a short list with extreme values at the head, the tail and inside.
    send_command(CMD_INS_POS, 32'sh7FFFFFFF, 8'd0);
    send_command(CMD_INS_TAIL, 32'sh80000000, 8'($urandom()));
    send_command(CMD_INS_HEAD, -32'sd1, 8'($urandom()));
    send_command(CMD_INS_POS, 32'sd0, 8'd3);
    send_command(CMD_INS_POS, 32'sd12345, 8'd2);
    // Out-of-range positions for both insert and remove.
    send_command(CMD_INS_POS, $urandom(), 8'd255);
    send_command(CMD_REM_POS, $urandom(), 8'd5);
    send_command(CMD_REM_POS, $urandom(), 8'd255);
    // Unused codes do nothing.
    send_command(CMD_RSVD6, $urandom(), 8'($urandom()));
    send_command(CMD_RSVD7, $urandom(), 8'($urandom()));
    // Remove the last entry, then check the tail moved back.
    send_command(CMD_REM_POS, $urandom(), 8'd4);
    send_command(CMD_REM_TAIL, $urandom(), 8'($urandom()));
    send_command(CMD_INS_TAIL, $urandom(), 8'($urandom()));
    send_command(CMD_REM_POS, $urandom(), 8'd1);
    send_command(CMD_REM_HEAD, $urandom(), 8'($urandom()));

    // Random part in segments; the first one leans heavily toward inserts to fill the list.
    insert_pct = 90;
    idle_pct   = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT == 0 && n != 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (n >= RANDOM_ITEMS - QUIET_TAIL) idle_pct = 0;
      if (n == RANDOM_ITEMS / 2) drain_results(1000);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 13));
      send_command(pick_code(insert_pct), $urandom(), pick_position());
    end

    drain_results(1000);
    repeat (4) @(posedge clk);

    $display("summary: %0d commands sent, %0d results checked, %0d mismatches",
             sent, checked, fail_count);
    $display("summary: status codes seen (full, bad position, empty, ok) = %b", status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
